@@ hdl/ats_pkg.sv @@
// package: types and constants for the alias table sampler
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;
    localparam int unsigned MAX_ENTRIES_DEF = 1024;
    localparam int unsigned WEIGHT_BITS_DEF = 16;
    localparam int unsigned IDX_OUT_W       = 10;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_NO_TABLE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_DRAW  = 1'b1;
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;
endpackage
`default_nettype wire

@@ hdl/ats_if.sv @@
// valid/ready stream interfaces for input and result transactions
`timescale 1ns / 1ps
`default_nettype none
interface ats_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] weight;
    logic        last;
    logic [31:0] rand_pick;
    logic [31:0] rand_accept;
    modport source (output valid, mode, weight, last, rand_pick, rand_accept, input ready);
    modport sink   (input valid, mode, weight, last, rand_pick, rand_accept, output ready);
endinterface

interface ats_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [9:0] sample_index;
    logic [1:0] status;
    modport source (output valid, kind, sample_index, status, input ready);
    modport sink   (input valid, kind, sample_index, status, output ready);
endinterface
`default_nettype wire

@@ hdl/ats_ram.sv @@
// generic single-port-write, one-read-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ats_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/alias_table_sampler_core.sv @@
// alias table sampler top level: load, build and draw sequencer over rams
//  channel | dir | handshake   | payload
//  in      | in  | valid/ready | mode, weight, last, rand_pick, rand_accept
//  out     | out | valid/ready | kind, sample_index, status
// load transaction without last: input ready again the cycle after acceptance
// draw with a table: multiply, table read and wait states, compare, then result valid
// build after last weight: scale every weight, classify into small and large lists,
// pair small with large columns, then fill the leftover columns before the report
// one shared multiplier serves scaling and draw arithmetic
// synchronous active-low reset clears count, sum and table flag; rams are not cleared
// input is not ready while a transaction is in work or a result waits
`timescale 1ns / 1ps
`default_nettype none
module alias_table_sampler_core
    import ats_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    ats_in_if.sink    i_in,
    ats_out_if.source o_out
);
    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned SW = WEIGHT_BITS + AW;
    localparam int unsigned PW = WEIGHT_BITS + CW;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SCALE_RD, S_SCALE_WT, S_SCALE_WR,
        S_CLS_RD, S_CLS_WT, S_CLS_WR,
        S_PAIR_POP, S_PAIR_WT, S_PAIR_RD, S_PAIR_WT2, S_PAIR_WR,
        S_LEFT_L, S_LEFT_LW, S_LEFT_S, S_LEFT_SW,
        S_DRAW_MUL, S_DRAW_RD, S_DRAW_WT, S_DRAW_CMP, S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [SW-1:0]    r_sum, n_sum;
    logic             r_ready_tbl, n_ready_tbl;
    logic             r_loading, n_loading;
    logic [CW-1:0]    r_i, n_i;
    logic [CW-1:0]    r_ns, n_ns, r_nl, n_nl;
    logic [AW-1:0]    r_a, n_a, r_g, n_g;
    logic [PW-1:0]    r_pa, n_pa;
    logic             r_kind, n_kind;
    logic [IDX_OUT_W-1:0] r_idx, n_idx;
    logic [1:0]       r_stat, n_stat;
    logic             r_ovalid, n_ovalid;
    logic [63:0]      r_prod, n_prod;
    logic [63:0]      r_accp, n_accp;
    logic [31:0]      r_r2, n_r2;
    logic [AW-1:0]    r_pick, n_pick;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // rams
    logic             w_we, p_we, s_we, l_we, t_we, al_we;
    logic [AW-1:0]    w_wa, w_ra, p_wa, p_ra, s_wa, s_ra, l_wa, l_ra, t_wa, t_ra, al_wa, al_ra;
    logic [WEIGHT_BITS-1:0] w_wd, w_rd;
    logic [PW-1:0]    p_wd, p_rd, t_wd, t_rd;
    logic [AW-1:0]    s_wd, s_rd, l_wd, l_rd, al_wd, al_rd;

    ats_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_ENTRIES)) u_weight (.i_clk, .i_we(w_we),
        .i_waddr(w_wa), .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    ats_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_scaled (.i_clk, .i_we(p_we),
        .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_small (.i_clk, .i_we(s_we),
        .i_waddr(s_wa), .i_wdata(s_wd), .i_raddr(s_ra), .o_rdata(s_rd));
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_large (.i_clk, .i_we(l_we),
        .i_waddr(l_wa), .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));
    ats_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_thresh (.i_clk, .i_we(t_we),
        .i_waddr(t_wa), .i_wdata(t_wd), .i_raddr(t_ra), .o_rdata(t_rd));
    ats_ram #(.WIDTH(AW), .DEPTH(MAX_ENTRIES)) u_alias (.i_clk, .i_we(al_we),
        .i_waddr(al_wa), .i_wdata(al_wd), .i_raddr(al_ra), .o_rdata(al_rd));

    logic in_acc;
    assign i_in.ready = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc     = i_in.valid && i_in.ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.kind         = r_kind;
    assign o_out.sample_index = r_idx;
    assign o_out.status       = r_stat;

    logic [PW-1:0] sum_pw, pg_new;
    logic [WEIGHT_BITS-1:0] w_in;
    assign sum_pw = PW'(r_sum);
    assign w_in   = WEIGHT_BITS'(i_in.weight);
    assign pg_new = p_rd + r_pa - sum_pw;

    logic [CW-1:0] cnt_base;
    logic [SW-1:0] sum_base;
    logic [95:0]   tshift;
    assign tshift = {32'(t_rd), 64'd0} >> 32;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_sum = r_sum; n_ready_tbl = r_ready_tbl;
        n_loading = r_loading; n_i = r_i; n_ns = r_ns; n_nl = r_nl; n_a = r_a; n_g = r_g;
        n_pa = r_pa; n_kind = r_kind; n_idx = r_idx; n_stat = r_stat; n_ovalid = r_ovalid;
        n_prod = r_prod; n_accp = r_accp; n_r2 = r_r2; n_pick = r_pick;
        mul_a = '0; mul_b = '0;
        w_we = 1'b0; w_wa = AW'(r_cnt); w_wd = w_in; w_ra = AW'(r_i);
        p_we = 1'b0; p_wa = AW'(r_i); p_wd = '0; p_ra = AW'(r_i);
        s_we = 1'b0; s_wa = AW'(r_ns); s_wd = AW'(r_i); s_ra = AW'(r_ns - 1'b1);
        l_we = 1'b0; l_wa = AW'(r_nl); l_wd = AW'(r_i); l_ra = AW'(r_nl - 1'b1);
        t_we = 1'b0; t_wa = r_a; t_wd = '0; t_ra = r_pick;
        al_we = 1'b0; al_wa = r_a; al_wd = r_g; al_ra = r_pick;
        cnt_base = r_loading ? r_cnt : '0;
        sum_base = r_loading ? r_sum : '0;
        if (o_out.ready && r_ovalid) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.mode == MODE_LOAD) begin
                        if (!r_loading) begin
                            n_ready_tbl = 1'b0;
                        end
                        n_loading = 1'b1;
                        w_wa = AW'(cnt_base);
                        if (cnt_base < CW'(MAX_ENTRIES)) begin
                            w_we  = 1'b1;
                            n_sum = sum_base + SW'(w_in);
                            n_cnt = cnt_base + 1'b1;
                        end else begin
                            n_sum = sum_base;
                            n_cnt = CW'(MAX_ENTRIES) + 1'b1; // overflow mark
                            if (cnt_base > CW'(MAX_ENTRIES)) n_cnt = cnt_base;
                        end
                        n_state = i_in.last ? S_LOAD : S_IDLE;
                    end else begin
                        n_kind = KIND_DRAW;
                        if (!r_ready_tbl) begin
                            n_idx = '0; n_stat = ST_NO_TABLE; n_state = S_OUT;
                        end else begin
                            n_r2 = i_in.rand_accept;
                            mul_a = 32'(r_cnt);
                            mul_b = i_in.rand_pick;
                            n_prod = mul_p;
                            n_state = S_DRAW_MUL;
                        end
                    end
                end
            end
            S_LOAD: begin
                n_loading = 1'b0; n_kind = KIND_BUILD; n_idx = '0;
                if (r_cnt > CW'(MAX_ENTRIES)) begin
                    n_stat = ST_OVERFLOW; n_state = S_OUT;
                end else if (r_sum == '0) begin
                    n_stat = ST_ZERO; n_state = S_OUT;
                end else begin
                    n_stat = ST_OK; n_i = '0; n_state = S_SCALE_RD;
                end
            end
            S_SCALE_RD: begin
                if (r_i == r_cnt) begin
                    n_i = r_cnt; n_ns = '0; n_nl = '0; n_state = S_CLS_RD;
                end else n_state = S_SCALE_WT;
            end
            S_SCALE_WT: n_state = S_SCALE_WR;
            S_SCALE_WR: begin
                mul_a = 32'(w_rd); mul_b = 32'(r_cnt);
                p_we = 1'b1; p_wd = PW'(mul_p);
                n_i = r_i + 1'b1; n_state = S_SCALE_RD;
            end
            S_CLS_RD: begin
                if (r_i == '0) n_state = S_PAIR_POP;
                else begin
                    n_i = r_i - 1'b1; n_state = S_CLS_WT;
                end
            end
            S_CLS_WT: n_state = S_CLS_WR;
            S_CLS_WR: begin
                if (p_rd < sum_pw) begin
                    s_we = 1'b1; n_ns = r_ns + 1'b1;
                end else begin
                    l_we = 1'b1; n_nl = r_nl + 1'b1;
                end
                n_state = S_CLS_RD;
            end
            S_PAIR_POP: begin
                if (r_ns != '0 && r_nl != '0) n_state = S_PAIR_WT;
                else n_state = S_LEFT_L;
            end
            S_PAIR_WT: begin
                n_a = s_rd; n_g = l_rd; n_ns = r_ns - 1'b1; n_nl = r_nl - 1'b1;
                n_state = S_PAIR_RD;
            end
            S_PAIR_RD: begin
                p_ra = r_a; n_state = S_PAIR_WT2;
            end
            S_PAIR_WT2: begin
                n_pa = p_rd; p_ra = r_g; n_state = S_PAIR_WR;
                t_we = 1'b1; t_wd = p_rd; al_we = 1'b1;
            end
            S_PAIR_WR: begin
                p_we = 1'b1; p_wa = r_g; p_wd = pg_new;
                if (pg_new < sum_pw) begin
                    s_we = 1'b1; s_wd = r_g; n_ns = r_ns + 1'b1;
                end else begin
                    l_we = 1'b1; l_wd = r_g; n_nl = r_nl + 1'b1;
                end
                n_state = S_PAIR_POP;
            end
            S_LEFT_L: begin
                if (r_nl != '0) n_state = S_LEFT_LW;
                else n_state = S_LEFT_S;
            end
            S_LEFT_LW: begin
                t_we = 1'b1; t_wa = l_rd; t_wd = sum_pw;
                al_we = 1'b1; al_wa = l_rd; al_wd = l_rd;
                n_nl = r_nl - 1'b1; n_state = S_LEFT_L;
            end
            S_LEFT_S: begin
                if (r_ns != '0) n_state = S_LEFT_SW;
                else begin
                    n_ready_tbl = 1'b1; n_state = S_OUT;
                end
            end
            S_LEFT_SW: begin
                t_we = 1'b1; t_wa = s_rd; t_wd = sum_pw;
                al_we = 1'b1; al_wa = s_rd; al_wd = s_rd;
                n_ns = r_ns - 1'b1; n_state = S_LEFT_S;
            end
            S_DRAW_MUL: begin
                if (r_prod[63:32] >= 32'(r_cnt)) n_pick = AW'(r_cnt - 1'b1);
                else n_pick = AW'(r_prod[63:32]);
                mul_a = r_r2; mul_b = 32'(r_sum);
                n_accp = mul_p;
                n_state = S_DRAW_RD;
            end
            S_DRAW_RD: n_state = S_DRAW_WT;
            S_DRAW_WT: n_state = S_DRAW_CMP;
            S_DRAW_CMP: begin
                n_stat = ST_OK;
                if (r_accp < tshift[63:0]) n_idx = IDX_OUT_W'(r_pick);
                else n_idx = IDX_OUT_W'(al_rd);
                n_state = S_OUT;
            end
            S_OUT: begin
                n_ovalid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_sum <= '0; r_ready_tbl <= 1'b0;
            r_loading <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_sum <= n_sum;
            r_ready_tbl <= n_ready_tbl; r_loading <= n_loading; r_ovalid <= n_ovalid;
        end
        r_i <= n_i; r_ns <= n_ns; r_nl <= n_nl; r_a <= n_a; r_g <= n_g; r_pa <= n_pa;
        r_kind <= n_kind; r_idx <= n_idx; r_stat <= n_stat; r_prod <= n_prod;
        r_accp <= n_accp; r_r2 <= n_r2; r_pick <= n_pick;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> r_ovalid) else $error("result dropped");
    a_no_in_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !i_in.ready) else $error("input taken with pending result");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ENTRIES) + 1'b1) else $error("count out of range");
endmodule
`default_nettype wire

@@ verif/alias_table_sampler_core_test.sv @@
// testbench: alias table sampler loads, builds and draws checked against an in-bench table model
`timescale 1ns / 1ps
`default_nettype none
module alias_table_sampler_core_test;
    import ats_pkg::*;

    localparam int unsigned ENTRIES    = MAX_ENTRIES_DEF;
    localparam int unsigned IDLE_LIMIT = 60000;
    localparam int unsigned RAND_ITEMS = 250;

    typedef struct packed {
        logic       kind;
        logic [9:0] sample_index;
        t_status    status;
    } sample_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ats_in_if  in_if ();
    ats_out_if out_if ();

    alias_table_sampler_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #10 i_clk = ~i_clk;

    // table model state
    longint unsigned tbl_weight [ENTRIES];
    longint unsigned tbl_scaled [ENTRIES];
    longint unsigned tbl_thresh [ENTRIES];
    longint unsigned tbl_alias  [ENTRIES];
    int unsigned     small_list [ENTRIES];
    int unsigned     large_list [ENTRIES];
    int unsigned     tbl_count;
    longint unsigned tbl_sum;
    bit              tbl_valid;
    bit              tbl_loading;

    sample_result_t  expected_results[$];
    int unsigned     error_count = 0;
    int unsigned     items_sent;
    int unsigned     burst_left;
    int unsigned     idle_cycles = 0;

    task automatic build_alias_table();
        int unsigned ns;
        int unsigned nl;
        int unsigned a;
        int unsigned g;
        ns = 0;
        nl = 0;
        for (int i = 0; i < tbl_count; i++) tbl_scaled[i] = tbl_weight[i] * tbl_count;
        for (int i = tbl_count; i > 0; i--) begin
            if (tbl_scaled[i-1] < tbl_sum) begin
                small_list[ns] = i - 1;
                ns++;
            end else begin
                large_list[nl] = i - 1;
                nl++;
            end
        end
        while (ns > 0 && nl > 0) begin
            ns--;
            nl--;
            a = small_list[ns];
            g = large_list[nl];
            tbl_thresh[a] = tbl_scaled[a];
            tbl_alias[a] = g;
            tbl_scaled[g] = tbl_scaled[g] + tbl_scaled[a] - tbl_sum;
            if (tbl_scaled[g] < tbl_sum) begin
                small_list[ns] = g;
                ns++;
            end else begin
                large_list[nl] = g;
                nl++;
            end
        end
        while (nl > 0) begin
            nl--;
            tbl_thresh[large_list[nl]] = tbl_sum;
            tbl_alias[large_list[nl]] = large_list[nl];
        end
        while (ns > 0) begin
            ns--;
            tbl_thresh[small_list[ns]] = tbl_sum;
            tbl_alias[small_list[ns]] = small_list[ns];
        end
    endtask

    task automatic predict_sampler(logic mode, logic [15:0] weight, logic last,
                                   logic [31:0] r_pick, logic [31:0] r_accept);
        sample_result_t  res;
        longint unsigned pick;
        longint unsigned lhs;
        longint unsigned rhs;
        res = '{kind: KIND_DRAW, sample_index: '0, status: ST_OK};
        if (mode == MODE_LOAD) begin
            if (!tbl_loading) begin
                tbl_count = 0;
                tbl_sum = 0;
                tbl_valid = 1'b0;
                tbl_loading = 1'b1;
            end
            if (tbl_count < ENTRIES) begin
                tbl_weight[tbl_count] = weight;
                tbl_sum += weight;
                tbl_count++;
            end else begin
                tbl_count = ENTRIES + 1;
            end
            if (!last) return;
            tbl_loading = 1'b0;
            res.kind = KIND_BUILD;
            if (tbl_count > ENTRIES) begin
                res.status = ST_OVERFLOW;
            end else if (tbl_sum == 0) begin
                res.status = ST_ZERO;
            end else begin
                build_alias_table();
                tbl_valid = 1'b1;
            end
        end else if (!tbl_valid || tbl_count == 0 || tbl_count > ENTRIES) begin
            res.status = ST_NO_TABLE;
        end else begin
            pick = (longint'(tbl_count) * r_pick) >> 32;
            if (pick >= tbl_count) pick = tbl_count - 1;
            lhs = longint'(r_accept) * tbl_sum;
            rhs = tbl_thresh[pick] << 32;
            res.sample_index = (lhs < rhs) ? pick[9:0] : tbl_alias[pick][9:0];
        end
        expected_results = {expected_results, res};
    endtask

    task automatic send_item(logic mode, logic [15:0] weight, logic last,
                             logic [31:0] r_pick, logic [31:0] r_accept);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid       <= 1'b1;
        in_if.mode        <= mode;
        in_if.weight      <= weight;
        in_if.last        <= last;
        in_if.rand_pick   <= r_pick;
        in_if.rand_accept <= r_accept;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        predict_sampler(mode, weight, last, r_pick, r_accept);
        items_sent++;
    endtask

    task automatic send_load(logic [15:0] weight, logic last);
        send_item(MODE_LOAD, weight, last, $urandom, $urandom);
    endtask

    task automatic send_draw(logic [31:0] r_pick, logic [31:0] r_accept);
        send_item(MODE_DRAW, 16'($urandom), 1'($urandom), r_pick, r_accept);
    endtask

    function automatic logic [15:0] pick_weight();
        unique case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3));
            2: return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
            default: return 16'($urandom) >> $urandom_range(0, 15);
        endcase
    endfunction

    task automatic test_draw_without_table();
        send_draw('0, '0);
        send_draw('1, '1);
    endtask

    task automatic test_extremes();
        send_load(16'hffff, 1'b1);
        send_draw('0, '0);
        send_draw('1, '1);
        send_load(16'h0000, 1'b1);
        send_draw(32'h8000_0000, 32'h8000_0000);
        send_load(16'h0000, 1'b0);
        send_load(16'h0000, 1'b0);
        send_load(16'h0001, 1'b1);
        send_draw('0, '1);
        send_draw('1, '0);
        send_load(16'hffff, 1'b0);
        send_draw('1, '1);
        send_load(16'h0001, 1'b0);
        send_load(16'h8000, 1'b1);
        send_draw(32'h5555_5555, 32'haaaa_aaaa);
        send_draw(32'haaaa_aaaa, 32'hffff_fffe);
        send_draw('1, '1);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < ENTRIES; i++) send_load(pick_weight(), i == ENTRIES - 1);
        repeat (20) send_draw($urandom, $urandom);
        send_draw('1, '1);
    endtask

    task automatic test_overflow();
        for (int i = 0; i <= ENTRIES; i++) send_load(16'($urandom), i == ENTRIES);
        send_draw($urandom, $urandom);
    endtask

    task automatic test_random();
        int unsigned n;
        int unsigned start;
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                for (int i = 0; i < n; i++) begin
                    send_load(pick_weight(), i == n - 1);
                    if ($urandom_range(0, 40) == 0) send_draw($urandom, $urandom);
                end
                repeat ($urandom_range(1, 20)) send_draw($urandom, $urandom);
            end else if ($urandom_range(0, 1) != 0) begin
                send_draw($urandom, $urandom);
            end else begin
                send_load(pick_weight(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // receiver with its own stall pattern
    int unsigned stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        unique case (stall_phase[8:7])
            2'd0: out_if.ready <= 1'b1;
            2'd1: out_if.ready <= 1'($urandom_range(0, 1));
            2'd2: out_if.ready <= (stall_phase[1:0] == 2'd0);
            default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        sample_result_t got;
        sample_result_t exp_res;
        if (out_if.valid && out_if.ready) begin
            got = '{kind: out_if.kind, sample_index: out_if.sample_index,
                    status: t_status'(out_if.status)};
            if (expected_results.size() == 0) begin
                $display("%0t unexpected transaction: kind %0d index %0d status %0d",
                         $time, got.kind, got.sample_index, got.status);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (got.kind !== exp_res.kind) begin
                    $display("%0t kind mismatch: expected %0d actual %0d",
                             $time, exp_res.kind, got.kind);
                    error_count++;
                end
                if (got.sample_index !== exp_res.sample_index) begin
                    $display("%0t sample_index mismatch: expected %0d actual %0d",
                             $time, exp_res.sample_index, got.sample_index);
                    error_count++;
                end
                if (got.status !== exp_res.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_res.status, got.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        in_if.valid       <= 1'b0;
        in_if.mode        <= MODE_LOAD;
        in_if.weight      <= '0;
        in_if.last        <= 1'b0;
        in_if.rand_pick   <= '0;
        in_if.rand_accept <= '0;
        tbl_count   = 0;
        tbl_sum     = 0;
        tbl_valid   = 1'b0;
        tbl_loading = 1'b0;
        items_sent  = 0;
        burst_left  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_draw_without_table();
        test_extremes();
        test_full_table();
        test_overflow();
        test_random();
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
